>>> rtl/core/siphash_keyed_hash_macros.svh
// ----------------------------------------------------------------------------
// SipHash keyed hash assertion macros
// Shared concurrent assertion forms for the keyed hash block.
// ----------------------------------------------------------------------------
`ifndef SIPHASH_KEYED_HASH_MACROS_SVH
`define SIPHASH_KEYED_HASH_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SHKH_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("siphash_keyed_hash: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SHKH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("siphash_keyed_hash: next-cycle check failed");

`endif

>>> rtl/core/shkh_pkg.sv
// ----------------------------------------------------------------------------
// SipHash keyed hash package
// Item types, controller/datapath interface types and fixed constants.
// ----------------------------------------------------------------------------
package shkh_pkg;

  localparam logic [63:0] INIT_0 = 64'h736f6d6570736575;
  localparam logic [63:0] INIT_1 = 64'h646f72616e646f6d;
  localparam logic [63:0] INIT_2 = 64'h6c7967656e657261;
  localparam logic [63:0] INIT_3 = 64'h7465646279746573;
  localparam logic [63:0] WIDE_TWEAK   = 64'h00000000000000ee;
  localparam logic [63:0] NARROW_TWEAK = 64'h00000000000000ff;
  localparam logic [63:0] SECOND_TWEAK = 64'h00000000000000dd;

  localparam int unsigned ADDR_W = 6;

  localparam logic [2:0] REG_KEY_LOW    = 3'd0;
  localparam logic [2:0] REG_KEY_HIGH   = 3'd1;
  localparam logic [2:0] REG_COMP_ROUND = 3'd2;
  localparam logic [2:0] REG_FIN_ROUND  = 3'd3;
  localparam logic [2:0] REG_WIDE       = 3'd4;

  typedef struct packed {
    logic [63:0] message_word;
    logic [3:0]  valid_bytes;
    logic        last_word;
  } in_item_t;

  typedef struct packed {
    logic [63:0] hash_low;
    logic [63:0] hash_high;
  } out_item_t;

  typedef struct packed {
    logic load_msg;
    logic do_round;
    logic close_block;
    logic load_tail;
    logic fin_tweak;
    logic second_tweak;
    logic take_lo;
    logic take_hi;
    logic clear_hi;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
    logic tail_pend;
  } dp_status_t;

endpackage

>>> rtl/core/shkh_datapath.sv
// ----------------------------------------------------------------------------
// SipHash keyed hash datapath
// Mixing words, block and length registers, one SipRound unit, result register.
// ----------------------------------------------------------------------------
module shkh_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  shkh_pkg::dp_cmd_t   cmd,
  output shkh_pkg::dp_status_t status,
  input  shkh_pkg::in_item_t  in_data,
  input  logic [63:0]         key_low,
  input  logic [63:0]         key_high,
  input  logic                wide,
  output shkh_pkg::out_item_t out_data
);
  import shkh_pkg::*;

  logic [63:0] v0_r, v1_r, v2_r, v3_r;
  logic [63:0] v0_nxt, v1_nxt, v2_nxt, v3_nxt;
  logic [63:0] r0, r1, r2, r3;
  logic [63:0] b0, b1, b2, b3;
  logic [7:0]  bc_r, bc_nxt, bc_sum;
  logic        in_msg_r, in_msg_nxt;
  logic [63:0] blk_r, blk_nxt;
  logic        last_r, last_nxt;
  logic        tail_pend_r, tail_pend_nxt;
  logic [63:0] hlo_r, hhi_r;
  out_item_t   out_r;
  logic [3:0]  nb;
  logic        full;
  logic [63:0] tail;
  logic [63:0] block;
  logic [63:0] digest;

  always_comb begin
    r0 = v0_r + v1_r;
    r1 = {v1_r[50:0], v1_r[63:51]} ^ r0;
    r0 = {r0[31:0], r0[63:32]};
    r2 = v2_r + v3_r;
    r3 = {v3_r[47:0], v3_r[63:48]} ^ r2;
    r0 = r0 + r3;
    r3 = {r3[42:0], r3[63:43]} ^ r0;
    r2 = r2 + r1;
    r1 = {r1[46:0], r1[63:47]} ^ r2;
    r2 = {r2[31:0], r2[63:32]};
  end

  assign digest = v0_r ^ v1_r ^ v2_r ^ v3_r;

  always_comb begin
    nb   = (in_data.valid_bytes > 4'd8) ? 4'd8 : in_data.valid_bytes;
    full = !in_data.last_word || nb[3];
    for (int i = 0; i < 8; i++) begin
      tail[8*i +: 8] = (4'(i) < nb) ? in_data.message_word[8*i +: 8] : 8'h00;
    end
    bc_sum = (in_msg_r ? bc_r : 8'd0) + (full ? 8'd8 : {4'd0, nb});
    block  = full ? in_data.message_word : (tail | {bc_sum, 56'd0});
    if (in_msg_r) begin
      b0 = v0_r;
      b1 = v1_r;
      b2 = v2_r;
      b3 = v3_r;
    end else begin
      b0 = INIT_0 ^ key_low;
      b1 = INIT_1 ^ key_high ^ (wide ? WIDE_TWEAK : 64'd0);
      b2 = INIT_2 ^ key_low;
      b3 = INIT_3 ^ key_high;
    end
  end

  always_comb begin
    v0_nxt = v0_r;
    v1_nxt = v1_r;
    v2_nxt = v2_r;
    v3_nxt = v3_r;
    bc_nxt = bc_r;
    in_msg_nxt = in_msg_r;
    blk_nxt = blk_r;
    last_nxt = last_r;
    tail_pend_nxt = tail_pend_r;
    if (cmd.do_round) begin
      v0_nxt = r0;
      v1_nxt = r1;
      v2_nxt = r2;
      v3_nxt = r3;
    end
    if (cmd.close_block) begin
      v0_nxt = v0_nxt ^ blk_r;
    end
    if (cmd.load_tail) begin
      blk_nxt = {bc_r, 56'd0};
      v3_nxt = v3_nxt ^ {bc_r, 56'd0};
      tail_pend_nxt = 1'b0;
    end
    if (cmd.fin_tweak) begin
      v2_nxt = v2_nxt ^ (wide ? WIDE_TWEAK : NARROW_TWEAK);
    end
    if (cmd.second_tweak) begin
      v1_nxt = v1_nxt ^ SECOND_TWEAK;
    end
    if (cmd.load_msg) begin
      v0_nxt = b0;
      v1_nxt = b1;
      v2_nxt = b2;
      v3_nxt = b3 ^ block;
      blk_nxt = block;
      bc_nxt = bc_sum;
      in_msg_nxt = 1'b1;
      last_nxt = in_data.last_word;
      tail_pend_nxt = in_data.last_word && full;
    end
    if (cmd.emit) begin
      in_msg_nxt = 1'b0;
      bc_nxt = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_msg_r <= 1'b0;
      bc_r <= 8'd0;
      last_r <= 1'b0;
      tail_pend_r <= 1'b0;
    end else begin
      in_msg_r <= in_msg_nxt;
      bc_r <= bc_nxt;
      last_r <= last_nxt;
      tail_pend_r <= tail_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v0_r <= v0_nxt;
    v1_r <= v1_nxt;
    v2_r <= v2_nxt;
    v3_r <= v3_nxt;
    blk_r <= blk_nxt;
    if (cmd.take_lo) begin
      hlo_r <= digest;
    end
    if (cmd.take_hi) begin
      hhi_r <= digest;
    end else if (cmd.clear_hi) begin
      hhi_r <= 64'd0;
    end
    if (cmd.emit) begin
      out_r.hash_low <= hlo_r;
      out_r.hash_high <= hhi_r;
    end
  end

  assign status.last = last_r;
  assign status.tail_pend = tail_pend_r;
  assign out_data = out_r;

endmodule

>>> rtl/core/shkh_ctrl.sv
// ----------------------------------------------------------------------------
// SipHash keyed hash controller
// Sequences absorption, finalization and result hand-off with a round counter.
// ----------------------------------------------------------------------------
module shkh_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  logic [7:0]           comp_rounds,
  input  logic [7:0]           fin_rounds,
  input  logic                 wide,
  input  shkh_pkg::dp_status_t status,
  output shkh_pkg::dp_cmd_t    cmd
);
  import shkh_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_COMP = 3'd1;
  localparam logic [2:0] ST_FIN1 = 3'd2;
  localparam logic [2:0] ST_FIN2 = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       cnt_zero;

  assign cnt_zero = (cnt_r == 8'd0);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    cmd = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_msg = 1'b1;
          cnt_nxt = comp_rounds;
          state_nxt = ST_COMP;
        end
      end
      ST_COMP: begin
        if (!cnt_zero) begin
          cmd.do_round = 1'b1;
          cnt_nxt = cnt_r - 8'd1;
        end else begin
          cmd.close_block = 1'b1;
          if (!status.last) begin
            state_nxt = ST_IDLE;
          end else if (status.tail_pend) begin
            cmd.load_tail = 1'b1;
            cnt_nxt = comp_rounds;
          end else begin
            cmd.fin_tweak = 1'b1;
            cnt_nxt = fin_rounds;
            state_nxt = ST_FIN1;
          end
        end
      end
      ST_FIN1: begin
        if (!cnt_zero) begin
          cmd.do_round = 1'b1;
          cnt_nxt = cnt_r - 8'd1;
        end else begin
          cmd.take_lo = 1'b1;
          if (wide) begin
            cmd.second_tweak = 1'b1;
            cnt_nxt = fin_rounds;
            state_nxt = ST_FIN2;
          end else begin
            cmd.clear_hi = 1'b1;
            state_nxt = ST_DONE;
          end
        end
      end
      ST_FIN2: begin
        if (!cnt_zero) begin
          cmd.do_round = 1'b1;
          cnt_nxt = cnt_r - 8'd1;
        end else begin
          cmd.take_hi = 1'b1;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.emit = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

>>> rtl/core/siphash_keyed_hash.sv
// ----------------------------------------------------------------------------
// SipHash keyed hash
// Keyed SipHash-c-d over little-endian 64-bit message words, 64- or 128-bit.
// ----------------------------------------------------------------------------
// One SipRound unit does all the mixing at one round per clock, and a single
// message word is in work at a time. Each word gets c rounds, where c is
// compression_rounds, and is then folded in before the next word is accepted;
// the default setting is 2-4. A last word that holds eight bytes gets c more
// rounds on the length block. Finalization then runs d rounds (d is
// finalization_rounds), d more in wide mode, and moves the hash into the
// output register. A finished hash waiting there does not block the next
// message; the block holds off only before a second hash would overwrite it.
`include "siphash_keyed_hash_macros.svh"

module siphash_keyed_hash (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  shkh_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output shkh_pkg::out_item_t                 out_data,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [shkh_pkg::ADDR_W-1:0]         paddr,
  input  logic [63:0]                         pwdata,
  output logic [63:0]                         prdata,
  output logic                                pready
);
  import shkh_pkg::*;

  logic [63:0] key_low_r, key_high_r;
  logic [7:0]  comp_rounds_r, fin_rounds_r;
  logic        wide_r;
  logic        cfg_wr;
  logic [2:0]  reg_idx;
  dp_cmd_t     cmd;
  dp_status_t  status;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign reg_idx = paddr[5:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r <= 64'd0;
      key_high_r <= 64'd0;
      comp_rounds_r <= 8'd2;
      fin_rounds_r <= 8'd4;
      wide_r <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_KEY_LOW:    key_low_r <= pwdata;
        REG_KEY_HIGH:   key_high_r <= pwdata;
        REG_COMP_ROUND: comp_rounds_r <= pwdata[7:0];
        REG_FIN_ROUND:  fin_rounds_r <= pwdata[7:0];
        REG_WIDE:       wide_r <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_KEY_LOW:    prdata = key_low_r;
      REG_KEY_HIGH:   prdata = key_high_r;
      REG_COMP_ROUND: prdata = {56'd0, comp_rounds_r};
      REG_FIN_ROUND:  prdata = {56'd0, fin_rounds_r};
      REG_WIDE:       prdata = {63'd0, wide_r};
      default:        prdata = 64'd0;
    endcase
  end

  shkh_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .comp_rounds (comp_rounds_r),
    .fin_rounds  (fin_rounds_r),
    .wide        (wide_r),
    .status      (status),
    .cmd         (cmd)
  );

  shkh_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .status   (status),
    .in_data  (in_data),
    .key_low  (key_low_r),
    .key_high (key_high_r),
    .wide     (wide_r),
    .out_data (out_data)
  );

  `SHKH_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
  `SHKH_ASSERT_SAME(a_no_overwrite, clk, rst_n, cmd.emit, !(out_valid && out_stall))
  `SHKH_ASSERT_SAME(a_emit_not_with_accept, clk, rst_n, cmd.emit, in_stall && !cmd.load_msg)

endmodule

>>> verif/tb_siphash_keyed_hash.sv
// ----------------------------------------------------------------------------
// SipHash keyed hash testbench
// Sends directed and random messages through the keyed hash block.
// Every hash is checked against a SipHash predictor in the bench or a fixed expected value.
// Register settings cover both output widths and round counts of 0, 255 and some in between.
// Idling is applied on both channels and a long hold-off on the output channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_siphash_keyed_hash;
  import shkh_pkg::*;

  localparam int unsigned CYCLE_LIMIT    = 400000;
  localparam int unsigned HOLDOFF_CYCLES = 400;
  localparam int unsigned DIR_ROWS       = 22;

  localparam logic [63:0] SIP_IV0   = 64'h736f6d6570736575;
  localparam logic [63:0] SIP_IV1   = 64'h646f72616e646f6d;
  localparam logic [63:0] SIP_IV2   = 64'h6c7967656e657261;
  localparam logic [63:0] SIP_IV3   = 64'h7465646279746573;
  localparam logic [63:0] TWEAK_W   = 64'hee;
  localparam logic [63:0] TWEAK_N   = 64'hff;
  localparam logic [63:0] TWEAK_HI  = 64'hdd;
  localparam logic [63:0] STD_KEY_L = 64'h0706050403020100;
  localparam logic [63:0] STD_KEY_H = 64'h0f0e0d0c0b0a0908;
  localparam logic [63:0] ALL_ONES  = 64'hffffffffffffffff;

  typedef struct packed {
    in_item_t    item;
    logic        typed;
    logic [63:0] typed_low;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  in_item_t          in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_item_t         out_data;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [63:0]       pwdata = '0;
  logic [63:0]       prdata;
  logic              pready;

  logic              receiver_hold = 1'b0;
  bit                holdoff_armed = 1'b0;
  int unsigned       sender_idle_pct = 0;
  int unsigned       recv_idle_pct = 0;
  int unsigned       cycle_count = 0;
  int unsigned       mismatch_count = 0;
  int unsigned       words_sent = 0;
  int unsigned       hashes_checked = 0;
  int unsigned       settings_used = 0;

  out_item_t         pending_hashes [$];

  logic [63:0]       key_lo_cfg;
  logic [63:0]       key_hi_cfg;
  logic [7:0]        comp_cfg;
  logic [7:0]        fin_cfg;
  logic              wide_cfg;
  logic [63:0]       mix [4];
  logic [7:0]        msg_bytes;
  bit                msg_open;

  dir_row_t directed_rows [DIR_ROWS] = '{
    '{'{64'h0000000000000000, 4'd0,  1'b1}, 1'b1, 64'h726fdb47dd0e0e31},
    '{'{ALL_ONES,             4'd8,  1'b1}, 1'b0, 64'h0},
    '{'{ALL_ONES,             4'd1,  1'b1}, 1'b0, 64'h0},
    '{'{64'h0706050403020100, 4'd7,  1'b1}, 1'b0, 64'h0},
    '{'{ALL_ONES,             4'd15, 1'b1}, 1'b0, 64'h0},
    '{'{64'h8000000000000001, 4'd9,  1'b1}, 1'b0, 64'h0},
    '{'{64'h0000000000000000, 4'd0,  1'b0}, 1'b0, 64'h0},
    '{'{ALL_ONES,             4'd15, 1'b0}, 1'b0, 64'h0},
    '{'{64'h0f0e0d0c0b0a0908, 4'd3,  1'b0}, 1'b0, 64'h0},
    '{'{64'hdeadbeefcafef00d, 4'd5,  1'b1}, 1'b0, 64'h0},
    '{'{64'h0123456789abcdef, 4'd8,  1'b0}, 1'b0, 64'h0},
    '{'{64'hfedcba9876543210, 4'd0,  1'b1}, 1'b0, 64'h0},
    '{'{64'haaaaaaaaaaaaaaaa, 4'd8,  1'b0}, 1'b0, 64'h0},
    '{'{64'h5555555555555555, 4'd8,  1'b1}, 1'b0, 64'h0},
    '{'{64'h0000000000000000, 4'd2,  1'b1}, 1'b0, 64'h0},
    '{'{ALL_ONES,             4'd4,  1'b1}, 1'b0, 64'h0},
    '{'{64'h0000000000000001, 4'd6,  1'b1}, 1'b0, 64'h0},
    '{'{64'h8000000000000000, 4'd10, 1'b0}, 1'b0, 64'h0},
    '{'{64'h7fffffffffffffff, 4'd12, 1'b0}, 1'b0, 64'h0},
    '{'{64'h00ff00ff00ff00ff, 4'd14, 1'b1}, 1'b0, 64'h0},
    '{'{64'h1122334455667788, 4'd13, 1'b1}, 1'b0, 64'h0},
    '{'{64'h99aabbccddeeff00, 4'd11, 1'b1}, 1'b0, 64'h0}
  };

  siphash_keyed_hash u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #1 clk = ~clk;

  function automatic logic [63:0] rotl64(logic [63:0] x, int unsigned s);
    return (x << s) | (x >> (64 - s));
  endfunction

  function automatic void sip_rounds(int unsigned count);
    for (int unsigned r = 0; r < count; r++) begin
      mix[0] = mix[0] + mix[1];
      mix[1] = rotl64(mix[1], 13) ^ mix[0];
      mix[0] = rotl64(mix[0], 32);
      mix[2] = mix[2] + mix[3];
      mix[3] = rotl64(mix[3], 16) ^ mix[2];
      mix[0] = mix[0] + mix[3];
      mix[3] = rotl64(mix[3], 21) ^ mix[0];
      mix[2] = mix[2] + mix[1];
      mix[1] = rotl64(mix[1], 17) ^ mix[2];
      mix[2] = rotl64(mix[2], 32);
    end
  endfunction

  function automatic void absorb_block(logic [63:0] blk);
    mix[3] = mix[3] ^ blk;
    sip_rounds(32'(comp_cfg));
    mix[0] = mix[0] ^ blk;
  endfunction

  // Returns 1 when the word closes a message and a hash is due.
  function automatic bit hash_message(input in_item_t it, output out_item_t res);
    logic [63:0] tail;
    int unsigned nb;
    res = '0;
    nb = 32'(it.valid_bytes);
    if (!msg_open) begin
      mix[0] = SIP_IV0 ^ key_lo_cfg;
      mix[1] = SIP_IV1 ^ key_hi_cfg;
      mix[2] = SIP_IV2 ^ key_lo_cfg;
      mix[3] = SIP_IV3 ^ key_hi_cfg;
      if (wide_cfg) begin
        mix[1] = mix[1] ^ TWEAK_W;
      end
      msg_bytes = 8'd0;
      msg_open = 1'b1;
    end
    if (!it.last_word || nb >= 8) begin
      absorb_block(it.message_word);
      msg_bytes = msg_bytes + 8'd8;
      if (!it.last_word) begin
        return 1'b0;
      end
      tail = '0;
    end else begin
      msg_bytes = msg_bytes + 8'(nb);
      tail = it.message_word & ((64'd1 << (8 * nb)) - 64'd1);
    end
    tail[63:56] = tail[63:56] | msg_bytes;
    absorb_block(tail);
    mix[2] = mix[2] ^ (wide_cfg ? TWEAK_W : TWEAK_N);
    sip_rounds(32'(fin_cfg));
    res.hash_low = mix[0] ^ mix[1] ^ mix[2] ^ mix[3];
    if (wide_cfg) begin
      mix[1] = mix[1] ^ TWEAK_HI;
      sip_rounds(32'(fin_cfg));
      res.hash_high = mix[0] ^ mix[1] ^ mix[2] ^ mix[3];
    end
    msg_open = 1'b0;
    msg_bytes = 8'd0;
    return 1'b1;
  endfunction

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 15))
      0: return 64'h0;
      1: return ALL_ONES;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s at %0t: got %h, expected %h", what, $time, got, want);
    mismatch_count++;
  endtask

  task automatic check_hash(out_item_t got);
    out_item_t want;
    if (pending_hashes.size() == 0) begin
      report_mismatch("hash with none pending", got.hash_low, 64'h0);
    end else begin
      want = pending_hashes.pop_front();
      hashes_checked++;
      if (got.hash_low !== want.hash_low) begin
        report_mismatch("hash_low", got.hash_low, want.hash_low);
      end
      if (got.hash_high !== want.hash_high) begin
        report_mismatch("hash_high", got.hash_high, want.hash_high);
      end
    end
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_KEY_LOW:    key_lo_cfg = value;
      REG_KEY_HIGH:   key_hi_cfg = value;
      REG_COMP_ROUND: comp_cfg = value[7:0];
      REG_FIN_ROUND:  fin_cfg = value[7:0];
      REG_WIDE:       wide_cfg = value[0];
      default: ;
    endcase
  endtask

  task automatic program_setting(logic [63:0] k0, logic [63:0] k1, logic [7:0] c,
                                 logic [7:0] d, logic w);
    write_reg(REG_KEY_LOW, k0);
    write_reg(REG_KEY_HIGH, k1);
    write_reg(REG_COMP_ROUND, {56'h0, c});
    write_reg(REG_FIN_ROUND, {56'h0, d});
    write_reg(REG_WIDE, {63'h0, w});
    settings_used++;
  endtask

  task automatic send_word(in_item_t it, logic typed, logic [63:0] typed_low);
    out_item_t predicted;
    if (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    words_sent++;
    if (hash_message(it, predicted)) begin
      if (typed) begin
        predicted.hash_low = typed_low;
        predicted.hash_high = 64'h0;
      end
      pending_hashes.push_back(predicted);
    end
  endtask

  task automatic send_random_message(bit short_only);
    in_item_t word_item;
    int unsigned nwords;
    if (short_only) begin
      nwords = $urandom_range(1, 3);
    end else if ($urandom_range(0, 9) == 0) begin
      nwords = $urandom_range(20, 40);
    end else begin
      nwords = $urandom_range(1, 5);
    end
    for (int unsigned w = 1; w <= nwords; w++) begin
      word_item.message_word = rand_word();
      word_item.last_word = (w == nwords);
      if (!word_item.last_word && $urandom_range(0, 3) != 0) begin
        word_item.valid_bytes = 4'd8;
      end else if ($urandom_range(0, 1) == 0) begin
        word_item.valid_bytes = 4'($urandom_range(0, 8));
      end else begin
        word_item.valid_bytes = 4'($urandom_range(0, 15));
      end
      send_word(word_item, 1'b0, 64'h0);
    end
  endtask

  // Called in the cycle of the last accepted item, so valid drops right away.
  task automatic drain_hashes();
    in_valid <= 1'b0;
    while (pending_hashes.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic run_phase(logic [63:0] k0, logic [63:0] k1, logic [7:0] c, logic [7:0] d,
                           logic w, int unsigned target, bit short_only, bit pause_mid,
                           bit with_holdoff);
    int unsigned first_word;
    bit paused;
    drain_hashes();
    repeat (2 * comp_cfg + 2 * fin_cfg + 16) @(posedge clk);
    program_setting(k0, k1, c, d, w);
    if (with_holdoff) begin
      holdoff_armed = 1'b1;
    end
    first_word = words_sent;
    paused = 1'b0;
    while (words_sent - first_word < target) begin
      if (pause_mid && !paused && words_sent - first_word >= target / 2) begin
        drain_hashes();
        paused = 1'b1;
      end
      send_random_message(short_only);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      check_hash(out_data);
    end
    out_stall <= receiver_hold || ($urandom_range(0, 99) < recv_idle_pct);
  end

  initial begin : receiver_holdoff
    wait (holdoff_armed);
    @(posedge clk);
    receiver_hold <= 1'b1;
    repeat (HOLDOFF_CYCLES) @(posedge clk);
    receiver_hold <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d hashes pending", cycle_count,
               pending_hashes.size());
      $display("siphash_keyed_hash test failed");
      $finish;
    end
  end

  initial begin : stimulus
    key_lo_cfg = 64'h0;
    key_hi_cfg = 64'h0;
    comp_cfg = 8'd2;
    fin_cfg = 8'd4;
    wide_cfg = 1'b0;
    mix[0] = 64'h0;
    mix[1] = 64'h0;
    mix[2] = 64'h0;
    mix[3] = 64'h0;
    msg_bytes = 8'd0;
    msg_open = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    program_setting(STD_KEY_L, STD_KEY_H, 8'd2, 8'd4, 1'b0);
    for (int i = 0; i < DIR_ROWS; i++) begin
      send_word(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].typed_low);
    end

    sender_idle_pct = 22;
    recv_idle_pct = 70;
    run_phase(rand_word(), rand_word(), 8'd2, 8'd4, 1'b0, 400, 1'b0, 1'b1, 1'b0);
    run_phase(rand_word(), rand_word(), 8'd2, 8'd4, 1'b1, 350, 1'b0, 1'b0, 1'b1);

    sender_idle_pct = 70;
    recv_idle_pct = 22;
    run_phase(rand_word(), rand_word(), 8'd1, 8'd3, 1'b1, 300, 1'b0, 1'b0, 1'b0);
    run_phase(64'h0, ALL_ONES, 8'd0, 8'd0, 1'b0, 200, 1'b0, 1'b0, 1'b0);

    sender_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(ALL_ONES, 64'h0, 8'd255, 8'd255, 1'b1, 20, 1'b1, 1'b0, 1'b0);
    run_phase(rand_word(), rand_word(), 8'd4, 8'd8, 1'b0, 300, 1'b0, 1'b0, 1'b0);
    run_phase(rand_word(), rand_word(), 8'($urandom_range(0, 6)), 8'($urandom_range(0, 6)),
              1'b1, 150, 1'b0, 1'b0, 1'b0);

    drain_hashes();
    repeat (2 * comp_cfg + 2 * fin_cfg + 16) @(posedge clk);

    $display("Sent %0d message words and checked %0d hashes over %0d register settings.",
             words_sent, hashes_checked, settings_used);
    $display("Round counts ran from 0 to 255 in both output widths, with idling and a hold-off.");
    if (mismatch_count == 0) begin
      $display("siphash_keyed_hash test passed");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("siphash_keyed_hash test failed");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/shkh_pkg.sv
rtl/core/shkh_datapath.sv
rtl/core/shkh_ctrl.sv
rtl/core/siphash_keyed_hash.sv
verif/tb_siphash_keyed_hash.sv
